/* rtl/aes128_block_encrypt_defines.svh */
// assertion macros for the aes-128 encryption block
// used by the port checker only
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH
// implication checked on every edge outside reset
`define AES_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("aes check failed");
// next-cycle implication
`define AES_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("aes check failed");
`endif

/* rtl/aes_pkg.sv */
// types, s-box and round helpers for the aes-128 encryption block
// no dependencies
package aes_pkg;
  localparam int NumRounds = 10;
  localparam logic [0:0] CfgKeyHigh = 1'b0;
  localparam logic [0:0] CfgKeyLow = 1'b1;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  typedef logic [127:0] rkey_t;

  // cell-to-cell handoff
  typedef struct packed {
    logic  vld;
    logic [127:0] st;
  } link_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1B;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  // next round key from the previous one
  function automatic rkey_t next_rkey(input rkey_t k, input logic [3:0] r);
    logic [31:0] w [4];
    logic [31:0] t;
    t = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])}
        ^ {rcon(r), 24'h0};
    w[0] = k[127:96] ^ t;
    w[1] = k[95:64] ^ w[0];
    w[2] = k[63:32] ^ w[1];
    w[3] = k[31:0] ^ w[2];
    return {w[0], w[1], w[2], w[3]};
  endfunction

  // byte i of the state sits at bits 127-8i
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r+4*c] = sbox(b[r+4*((c+r)%4)]);
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o;
  endfunction
endpackage

/* rtl/aes_key_cell.sv */
// one step of the key schedule: holds round key r, derived from its neighbor
// depends on aes_pkg
module aes_key_cell (
  input  logic          clk,
  input  logic [3:0]    rnd,
  input  aes_pkg::rkey_t prev_key,
  output aes_pkg::rkey_t key
);
  aes_pkg::rkey_t key_r;
  aes_pkg::rkey_t key_nxt;

  assign key_nxt = aes_pkg::next_rkey(prev_key, rnd);

  // ripples one cell per cycle after a key write
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;
endmodule

/* rtl/aes_round_cell.sv */
// one cipher round cell: sub/shift/mix (no mix in the last round) of the incoming state plus its round key
// depends on aes_pkg
module aes_round_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           last,
  input  aes_pkg::rkey_t key,
  input  aes_pkg::link_t link_in,
  output aes_pkg::link_t link_out
);
  logic         vld_r;
  logic [127:0] st_r;
  logic [127:0] st_nxt;

  assign st_nxt = aes_pkg::round_fn(link_in.st, last) ^ key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= link_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign link_out = '{vld: vld_r, st: st_r};
endmodule

/* rtl/aes128_block_encrypt.sv */
// Channel  | dir | handshake             | payload
// in       | in  | start & !busy         | in_data (plain_high, plain_low)
// out      | out | out_valid, one cycle  | out_data (cipher_high, cipher_low)
// cfg      | in  | cfg_valid & cfg_ready | cfg_index, cfg_wdata
// One item per cycle; each item passes the input register, then one cell per round.
// The key schedule ripples through ten key cells after a key write; a cell's round
// key is the one its item needs if the user changes keys only when idle; the block itself does not enforce this.
// busy stays low; reset clears valid bits and key registers, round keys re-derive from zero.
module aes128_block_encrypt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  aes_pkg::in_item_t  in_data,
  output logic               out_valid,
  output aes_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);
  logic [63:0] key_high_r;
  logic [63:0] key_low_r;
  aes_pkg::rkey_t rk [aes_pkg::NumRounds+1];
  aes_pkg::link_t lk [aes_pkg::NumRounds+1];
  logic         v0_r;
  logic [127:0] s0_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
      if (cfg_valid && cfg_index == aes_pkg::CfgKeyHigh) key_high_r <= cfg_wdata;
      if (cfg_valid && cfg_index == aes_pkg::CfgKeyLow) key_low_r <= cfg_wdata;
    end
  end

  // initial add round key
  always_ff @(posedge clk) begin
    s0_r <= {in_data.plain_high, in_data.plain_low} ^ {key_high_r, key_low_r};
  end

  assign rk[0] = {key_high_r, key_low_r};
  assign lk[0] = '{vld: v0_r, st: s0_r};

  for (genvar g = 1; g <= aes_pkg::NumRounds; g++) begin : g_cell
    aes_key_cell u_key (
      .clk(clk), .rnd(4'(g)), .prev_key(rk[g-1]), .key(rk[g])
    );
    aes_round_cell u_rnd (
      .clk(clk), .rst_n(rst_n), .last(g == aes_pkg::NumRounds), .key(rk[g]),
      .link_in(lk[g-1]), .link_out(lk[g])
    );
  end

  assign out_valid = lk[aes_pkg::NumRounds].vld;
  assign out_data = lk[aes_pkg::NumRounds].st;
endmodule

/* rtl/aes_check.sv */
// port checker for the aes-128 encryption block, bound to the top level
// depends on aes_pkg and aes128_block_encrypt_defines.svh
`include "aes128_block_encrypt_defines.svh"
module aes_check (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);
  `AES_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy)
  `AES_ASSERT_IMP(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)
  `AES_ASSERT_NEXT(a_latency, clk, rst_n, $past(start, 10) && $past(rst_n, 11), out_valid)
  `AES_ASSERT_NEXT(a_no_spurious, clk, rst_n, !$past(start, 10) && $past(rst_n, 11), !out_valid)
endmodule

bind aes128_block_encrypt aes_check u_aes_check (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .cfg_ready(cfg_ready)
);
